FILE: rtl/core/ssg_pkg.sv
// Types, constants and the arctangent table shared by the seek steering guidance unit.
package ssg_pkg;

    localparam int XW       = 36;
    localparam int ZW       = 28;
    localparam int EW       = 25;
    localparam int ANG_FRAC = 24;
    localparam int DIST_W   = 26;

    localparam logic signed [ZW-1:0] PI_Z       = 28'sd52707179;
    localparam logic signed [17:0]   PI_Q13     = 18'sd25736;
    localparam logic signed [17:0]   TWO_PI_Q13 = 18'sd51472;
    localparam logic [29:0]          GAIN_Q30   = 30'd652032874;
    localparam logic [16:0]          DIV3_RECIP = 17'd43691;
    localparam logic [DIST_W-1:0]    DIST_MAX   = 26'h3FFFFFF;

    typedef enum logic [1:0] {
        CFG_GOAL_X = 2'd0,
        CFG_GOAL_Y = 2'd1,
        CFG_CRUISE = 2'd2,
        CFG_TOL    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                 zero;
        logic signed [15:0]   yaw;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned idx);
        logic [ZW-1:0] one;
        one = ZW'(1);
        case (idx)
            0:       atan_entry = 28'sd13176795;
            1:       atan_entry = 28'sd7778716;
            2:       atan_entry = 28'sd4110060;
            3:       atan_entry = 28'sd2086331;
            4:       atan_entry = 28'sd1047214;
            5:       atan_entry = 28'sd524117;
            6:       atan_entry = 28'sd262123;
            7:       atan_entry = 28'sd131069;
            default: atan_entry = $signed(one << (ANG_FRAC - idx));
        endcase
    endfunction

endpackage

FILE: rtl/core/seek_steering_guidance_unit.sv
// Top level of the seek steering guidance unit: config registers and the pipeline.
// Usage:
//   The slave stream takes one pose per item: tdata holds pos_x, pos_y (Q12.12) and
//   yaw (Q3.13). The master stream gives one result per pose: desired_speed,
//   desired_heading, moving and distance. The config port writes goal_x, goal_y,
//   cruise_speed and arrive_tolerance by index; write it only while the unit is idle.
//   Throughput is one item per cycle while the receiver does not stall. Each pose passes
//   through the error and quadrant pre-rotation registers, the registered cells of the
//   CORDIC row, then the gain multiply, heading wrap and speed banding registers, the
//   last of which is the output register.
//   The whole pipeline advances together; when the receiver stalls with a result in
//   the output register, s_axis_tready drops and every stage holds. Every stage
//   advances while the output register is empty or being read.
//   Reset clears all stage valid flags and the config registers to zero; no clearing
//   pass is needed.
module seek_steering_guidance_unit
    import ssg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // pos_x[23:0], pos_y[47:24], yaw[63:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // desired_speed[15:0], desired_heading[31:16],
                                       // moving[32], distance[58:33], zero[63:59]
);

    logic signed [23:0] r_goal_x;
    logic signed [23:0] r_goal_y;
    logic [15:0]        r_cruise;
    logic [23:0]        r_tol;
    logic               w_en;
    logic               w_cv [CORDIC_STAGES+1];
    t_cordic            w_cd [CORDIC_STAGES+1];
    logic [15:0]        w_speed;
    logic signed [15:0] w_heading;
    logic               w_moving;
    logic [DIST_W-1:0]  w_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_cruise <= '0;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_GOAL_X: r_goal_x <= i_cfg_wdata;
                CFG_GOAL_Y: r_goal_y <= i_cfg_wdata;
                CFG_CRUISE: r_cruise <= i_cfg_wdata[15:0];
                CFG_TOL:    r_tol    <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    ssg_pre u_pre (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s_axis_tvalid),
        .i_pos_x  (s_axis_tdata[23:0]),
        .i_pos_y  (s_axis_tdata[47:24]),
        .i_yaw    (s_axis_tdata[63:48]),
        .i_goal_x (r_goal_x),
        .i_goal_y (r_goal_y),
        .o_valid  (w_cv[0]),
        .o_data   (w_cd[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ssg_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_data  (w_cd[g]),
            .o_valid (w_cv[g+1]),
            .o_data  (w_cd[g+1])
        );
    end

    ssg_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_cv[CORDIC_STAGES]),
        .i_data     (w_cd[CORDIC_STAGES]),
        .i_cruise   (r_cruise),
        .i_tol      (r_tol),
        .o_valid    (m_axis_tvalid),
        .o_speed    (w_speed),
        .o_heading  (w_heading),
        .o_moving   (w_moving),
        .o_distance (w_distance)
    );

    assign m_axis_tdata = {5'b0, w_distance, w_moving, w_heading, w_speed};

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(w_heading) >= -16'sd25736)
                          && ($signed(w_heading) <= 16'sd25735))
        else $error("heading outside the wrapped range");

    a_stop_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_moving |-> w_speed == '0)
        else $error("nonzero speed while arrived");

    a_arrive_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_distance < {2'b0, r_tol}) |-> !w_moving)
        else $error("moving inside the arrival tolerance");

    a_cruise_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_distance >= ({1'b0, r_tol, 1'b0} + {2'b0, r_tol}))
        |-> w_moving && (w_speed == r_cruise))
        else $error("cruise speed not applied far from the goal");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_cd[CORDIC_STAGES]) && $stable(w_cv[CORDIC_STAGES]))
        else $error("CORDIC row advanced during a stall");

endmodule

FILE: rtl/core/ssg_pre.sv
// Error vector to the goal and quadrant pre-rotation ahead of the CORDIC row.
module ssg_pre
    import ssg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [15:0] i_yaw,
    input  logic signed [23:0] i_goal_x,
    input  logic signed [23:0] i_goal_y,
    output logic               o_valid,
    output t_cordic            o_data
);

    logic                 r_v0;
    logic signed [EW-1:0] r_ex;
    logic signed [EW-1:0] r_ey;
    logic signed [15:0]   r_yaw0;
    t_cordic              n_data;
    t_cordic              r_data;
    logic                 r_v1;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex   <= {i_goal_x[23], i_goal_x} - {i_pos_x[23], i_pos_x};
            r_ey   <= {i_goal_y[23], i_goal_y} - {i_pos_y[23], i_pos_y};
            r_yaw0 <= i_yaw;
            r_data <= n_data;
        end
    end

    always_comb begin
        w_xs        = {{3{r_ex[EW-1]}}, r_ex, 8'b0};
        w_ys        = {{3{r_ey[EW-1]}}, r_ey, 8'b0};
        n_data.zero = (r_ex == '0) && (r_ey == '0);
        n_data.yaw  = r_yaw0;
        if (r_ex[EW-1]) begin
            n_data.x = -w_xs;
            n_data.y = -w_ys;
            n_data.z = r_ey[EW-1] ? -PI_Z : PI_Z;
        end else begin
            n_data.x = w_xs;
            n_data.y = w_ys;
            n_data.z = '0;
        end
    end

    assign o_valid = r_v1;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/ssg_cell.sv
// One vectoring CORDIC micro-rotation cell of the row.
module ssg_cell
    import ssg_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_cordic i_data,
    output logic    o_valid,
    output t_cordic o_data
);

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_at;
    t_cordic              n_data;
    t_cordic              r_data;
    logic                 r_valid;

    always_comb begin
        w_xs        = $signed(i_data.x) >>> STAGE;
        w_ys        = $signed(i_data.y) >>> STAGE;
        w_at        = atan_entry(STAGE);
        n_data.zero = i_data.zero;
        n_data.yaw  = i_data.yaw;
        if (!i_data.y[XW-1]) begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + w_at;
        end else begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/ssg_post.sv
// Gain compensation, heading wrap, speed bands and the output register.
module ssg_post
    import ssg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_cordic           i_data,
    input  logic [15:0]       i_cruise,
    input  logic [23:0]       i_tol,
    output logic              o_valid,
    output logic [15:0]       o_speed,
    output logic signed [15:0] o_heading,
    output logic              o_moving,
    output logic [DIST_W-1:0] o_distance
);

    // stage A
    logic [XW-2:0]        w_xpos;
    logic signed [ZW-1:0] w_zr;
    logic signed [16:0]   w_bearing;
    logic                 r_va;
    logic                 r_zero_a;
    logic [47:0]          r_plo;
    logic [46:0]          r_phi;
    logic signed [17:0]   r_hraw;
    // stage B
    logic [65:0]          w_sum;
    logic [27:0]          w_dfull;
    logic [DIST_W-1:0]    w_dist;
    logic signed [17:0]   w_h1;
    logic signed [17:0]   w_h2;
    logic                 r_vb;
    logic [DIST_W-1:0]    r_dist;
    logic signed [15:0]   r_head_b;
    // stage C
    logic [DIST_W-1:0]    w_tol;
    logic [DIST_W-1:0]    w_tol3;
    logic [32:0]          w_div3p;
    logic [15:0]          n_speed;
    logic                 n_moving;
    logic                 r_vc;
    logic [15:0]          r_speed;
    logic signed [15:0]   r_heading;
    logic                 r_moving;
    logic [DIST_W-1:0]    r_distance;

    always_comb begin
        w_xpos    = i_data.x[XW-1] ? '0 : i_data.x[XW-2:0];
        w_zr      = i_data.z + ZW'(1024);
        w_bearing = i_data.zero ? '0 : w_zr[ZW-1:11];
    end

    always_comb begin
        w_sum   = {1'b0, r_phi, 18'b0} + {18'b0, r_plo} + (66'd1 << 37);
        w_dfull = w_sum[65:38];
        if (r_zero_a) begin
            w_dist = '0;
        end else if (w_dfull > {2'b0, DIST_MAX}) begin
            w_dist = DIST_MAX;
        end else begin
            w_dist = w_dfull[DIST_W-1:0];
        end
        if (r_hraw >= PI_Q13) begin
            w_h1 = r_hraw - TWO_PI_Q13;
        end else if (r_hraw < -PI_Q13) begin
            w_h1 = r_hraw + TWO_PI_Q13;
        end else begin
            w_h1 = r_hraw;
        end
        if (w_h1 >= PI_Q13) begin
            w_h2 = w_h1 - TWO_PI_Q13;
        end else if (w_h1 < -PI_Q13) begin
            w_h2 = w_h1 + TWO_PI_Q13;
        end else begin
            w_h2 = w_h1;
        end
    end

    always_comb begin
        w_tol   = {2'b0, i_tol};
        w_tol3  = {1'b0, i_tol, 1'b0} + w_tol;
        w_div3p = i_cruise * DIV3_RECIP;
        if (r_dist < w_tol) begin
            n_speed  = '0;
            n_moving = 1'b0;
        end else if (r_dist < w_tol3) begin
            n_speed  = w_div3p[32:17];
            n_moving = 1'b1;
        end else begin
            n_speed  = i_cruise;
            n_moving = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero_a   <= i_data.zero;
            r_plo      <= w_xpos[17:0] * GAIN_Q30;
            r_phi      <= w_xpos[34:18] * GAIN_Q30;
            r_hraw     <= {w_bearing[16], w_bearing} - {{2{i_data.yaw[15]}}, i_data.yaw};
            r_dist     <= w_dist;
            r_head_b   <= w_h2[15:0];
            r_speed    <= n_speed;
            r_heading  <= r_head_b;
            r_moving   <= n_moving;
            r_distance <= r_dist;
        end
    end

    assign o_valid    = r_vc;
    assign o_speed    = r_speed;
    assign o_heading  = r_heading;
    assign o_moving   = r_moving;
    assign o_distance = r_distance;

endmodule

FILE: dv/ssg_checker.sv
// Checker for the seek steering guidance unit: watches all ports, predicts and compares.
`timescale 1ns / 100ps

module ssg_checker
    import ssg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // pos_x[23:0], pos_y[47:24], yaw[63:48]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,  // desired_speed[15:0], desired_heading[31:16],
                                       // moving[32], distance[58:33], zero[63:59]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_stopped,
    output int          o_slowed,
    output int          o_cruising
);

    localparam longint CZ_PI     = 52707179;
    localparam longint GAIN_COMP = 64'd652032874;
    localparam longint HALF_TURN = 25736;
    localparam longint FULL_TURN = 51472;
    localparam longint DIST_TOP  = 67108863;
    localparam longint ATAN_HEAD [8] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069
    };

    typedef struct packed {
        logic [25:0]        distance;
        logic               moving;
        logic signed [15:0] heading;
        logic [15:0]        speed;
    } t_guidance;

    longint      goal_x;
    longint      goal_y;
    longint      cruise;
    longint      tolerance;
    t_guidance   guidance_due [$];

    function automatic t_guidance steer_toward_goal(input logic signed [23:0] px,
                                                    input logic signed [23:0] py,
                                                    input logic signed [15:0] yaw);
        t_guidance   g;
        longint      ex;
        longint      ey;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      sx;
        longint      sy;
        longint      step;
        longint      goal_range;
        longint      bearing;
        longint      rel;
        logic [63:0] prod;
        int          i;
        ex = goal_x - longint'(px);
        ey = goal_y - longint'(py);
        if (ex == 0 && ey == 0) begin
            goal_range = 0;
            bearing    = 0;
        end else begin
            cx = ex * 256;
            cy = ey * 256;
            cz = 0;
            // fold the left half plane onto the right one
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                cz = (ey >= 0) ? CZ_PI : -CZ_PI;
            end
            for (i = 0; i < CORDIC_STAGES && i < 24; i++) begin
                sx   = cx >>> i;
                sy   = cy >>> i;
                step = (i < 8) ? ATAN_HEAD[i] : (longint'(1) <<< (24 - i));
                if (cy >= 0) begin
                    cx = cx + sy;
                    cy = cy - sx;
                    cz = cz + step;
                end else begin
                    cx = cx - sy;
                    cy = cy + sx;
                    cz = cz - step;
                end
            end
            if (cx < 0) begin
                cx = 0;
            end
            prod       = 64'(cx) * GAIN_COMP + (64'd1 << 37);
            goal_range = longint'(prod >> 38);
            if (goal_range > DIST_TOP) begin
                goal_range = DIST_TOP;
            end
            bearing = (cz + 1024) >>> 11;
        end
        rel = bearing - longint'(yaw);
        while (rel >= HALF_TURN) begin
            rel = rel - FULL_TURN;
        end
        while (rel < -HALF_TURN) begin
            rel = rel + FULL_TURN;
        end
        if (goal_range < tolerance) begin
            g.speed  = '0;
            g.moving = 1'b0;
        end else if (goal_range < 3 * tolerance) begin
            g.speed  = 16'(cruise / 3);
            g.moving = 1'b1;
        end else begin
            g.speed  = 16'(cruise);
            g.moving = 1'b1;
        end
        g.heading  = 16'(rel);
        g.distance = 26'(goal_range);
        return g;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 20) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_guidance want;
        t_guidance got;
        if (!i_rst_n) begin
            goal_x       = 0;
            goal_y       = 0;
            cruise       = 0;
            tolerance    = 0;
            o_fail_count = 0;
            o_checked    = 0;
            o_stopped    = 0;
            o_slowed     = 0;
            o_cruising   = 0;
            guidance_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GOAL_X: goal_x    = longint'($signed(i_cfg_wdata));
                    CFG_GOAL_Y: goal_y    = longint'($signed(i_cfg_wdata));
                    CFG_CRUISE: cruise    = longint'(i_cfg_wdata[15:0]);
                    CFG_TOL:    tolerance = longint'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                guidance_due.push_back(steer_toward_goal(s_axis_tdata[23:0],
                                                         s_axis_tdata[47:24],
                                                         s_axis_tdata[63:48]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[58:0];
                if (guidance_due.size() == 0) begin
                    report_mismatch("result arrived with none pending");
                end else begin
                    want = guidance_due.pop_front();
                    o_checked++;
                    if (!want.moving) begin
                        o_stopped++;
                    end else if (want.speed != 16'(cruise) || cruise == 0) begin
                        o_slowed++;
                    end else begin
                        o_cruising++;
                    end
                    if (got.speed !== want.speed) begin
                        report_mismatch($sformatf("speed got %0d want %0d",
                                                  got.speed, want.speed));
                    end
                    if (got.heading !== want.heading) begin
                        report_mismatch($sformatf("heading got %0d want %0d",
                                                  got.heading, want.heading));
                    end
                    if (got.moving !== want.moving) begin
                        report_mismatch($sformatf("moving got %0b want %0b",
                                                  got.moving, want.moving));
                    end
                    if (got.distance !== want.distance) begin
                        report_mismatch($sformatf("distance got %0d want %0d",
                                                  got.distance, want.distance));
                    end
                    if (m_axis_tdata[63:59] !== 5'd0) begin
                        report_mismatch($sformatf("pad bits got %b",
                                                  m_axis_tdata[63:59]));
                    end
                end
            end
        end
        o_pending <= guidance_due.size();
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the seek steering guidance unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import ssg_pkg::*;

    localparam int STAGES     = 16;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 317;
    localparam int CYCLE_CAP  = 1000000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [23:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int stopped;
    int slowed;
    int cruising;

    logic               free_flow = 1'b0;
    int                 rx_hold   = 0;
    int                 poses_sent = 0;
    int                 settings_used = 0;
    logic signed [23:0] cur_gx = '0;
    logic signed [23:0] cur_gy = '0;

    seek_steering_guidance_unit #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ssg_checker #(
        .CORDIC_STAGES(STAGES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_stopped     (stopped),
        .o_slowed      (slowed),
        .o_cruising    (cruising)
    );

    always #6 i_clk = ~i_clk;

    // receiver: random stalls, mostly short, a few long
    always @(posedge i_clk) begin
        int r;
        if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
        end else if (free_flow) begin
            m_axis_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_axis_tready <= 1'b1;
                rx_hold = $urandom_range(0, 4);
            end else if (r < 93) begin
                m_axis_tready <= 1'b0;
                rx_hold = $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rx_hold = $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (free_flow || r < 65) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pose(input logic [23:0] px, input logic [23:0] py,
                             input logic [15:0] yaw);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, py, px};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        poses_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [23:0] gx, input logic [23:0] gy,
                                  input logic [23:0] cruise_word, input logic [23:0] tol);
        cfg_write(CFG_GOAL_X, gx);
        cfg_write(CFG_GOAL_Y, gy);
        cfg_write(CFG_CRUISE, cruise_word);
        cfg_write(CFG_TOL, tol);
        i_cfg_we <= 1'b0;
        cur_gx = gx;
        cur_gy = gy;
        settings_used++;
    endtask

    // time limit
    initial begin
        repeat (CYCLE_CAP) @(posedge i_clk);
        $display("** seek_steering_guidance_unit: FAILED **");
        $finish;
    end

    initial begin
        int          ph;
        int          n;
        int          k;
        int          span;
        int          r;
        logic [23:0] px;
        logic [23:0] py;
        logic [15:0] yaw;
        logic [23:0] tol;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: goal at origin, zero cruise, zero tolerance
        send_pose(24'sd0, 24'sd0, 16'sd0);
        send_pose(24'sd0, 24'sd0, 16'sh7FFF);
        send_pose(24'sd0, 24'sd0, 16'sh8000);
        send_pose(-24'sd8388608, -24'sd8388608, 16'sd25736);
        send_pose(24'sd8388607, 24'sd8388607, -16'sd25736);
        send_pose(24'sd8388607, 24'sd0, 16'sd0);
        send_pose(24'sd8388607, 24'sd1, 16'sd0);
        send_pose(24'sd0, -24'sd1, 16'sd0);
        drain_results();

        // corner goal, full cruise, one metre tolerance: band edges on the x axis
        apply_settings(24'sd8388607, -24'sd8388608, 24'hFFFFFF, 24'd4096);
        send_pose(-24'sd8388608, 24'sd8388607, 16'sd0);
        send_pose(24'sd8388607, -24'sd8388608, 16'sd100);
        send_pose(24'sd8388607 - 24'sd4095, -24'sd8388608, 16'sd0);
        send_pose(24'sd8388607 - 24'sd4096, -24'sd8388608, 16'sd0);
        send_pose(24'sd8388607 - 24'sd4097, -24'sd8388608, 16'sd0);
        send_pose(24'sd8388607 - 24'sd12287, -24'sd8388608, 16'sd0);
        send_pose(24'sd8388607 - 24'sd12288, -24'sd8388608, 16'sd0);
        send_pose(24'sd8388607 - 24'sd12289, -24'sd8388608, 16'sd0);
        send_pose(24'sd8388607, -24'sd8388608 + 24'sd8000, 16'sh7FFF);
        send_pose(24'sd8388607, -24'sd8388608 + 24'sd3, 16'sh8000);
        drain_results();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings(24'sd8388607, 24'sd8388607, 24'd65535, 24'd0);
                1: apply_settings(-24'sd8388608, -24'sd8388608,
                                  {8'($urandom), 16'd0}, 24'hFFFFFF);
                default: begin
                    tol = 24'($urandom_range(0, (1 << $urandom_range(0, 24)) - 1));
                    apply_settings(24'($urandom), 24'($urandom), 24'($urandom), tol);
                end
            endcase
            free_flow = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_LEN; n++) begin
                if (ph == 3 && n == PHASE_LEN / 2) begin
                    drain_results();
                end
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    px = cur_gx;
                    py = cur_gy;
                end else if (r < 73) begin
                    k    = $urandom_range(0, 24);
                    span = 1 << k;
                    px   = 24'(int'(cur_gx) - (int'($urandom_range(0, 2 * span)) - span));
                    py   = 24'(int'(cur_gy) - (int'($urandom_range(0, 2 * span)) - span));
                end else begin
                    px = 24'($urandom);
                    py = 24'($urandom);
                end
                if ($urandom_range(0, 4) == 0) begin
                    yaw = 16'($urandom);
                end else begin
                    yaw = 16'(int'($urandom_range(0, 51472)) - 25736);
                end
                send_pose(px, py, yaw);
            end
            drain_results();
        end
        free_flow = 1'b0;

        repeat (STAGES + 8) @(posedge i_clk);
        $display("%0d poses under %0d register settings, %0d results compared",
                 poses_sent, settings_used, checked);
        $display("speed bands seen: %0d arrived, %0d reduced, %0d cruise",
                 stopped, slowed, cruising);
        if (fail_count == 0 && pending == 0) begin
            $display("** seek_steering_guidance_unit: PASSED **");
        end else begin
            $display("** seek_steering_guidance_unit: FAILED **");
        end
        $finish;
    end

endmodule
